FILE: sv/ltrm_pkg.sv
// ----------------------------------------------------------------------------
// ltrm_pkg
// Shared types and constants for the link throughput rate meter: item
// structs, controller command and status groups, state and source codes.
// ----------------------------------------------------------------------------
package ltrm_pkg;

  localparam int CNT_W   = 64;
  localparam int NUM_CNT = 4;
  localparam int IDX_W   = 2;
  localparam int LVL_W   = 8;
  localparam int SLOT_OUT_W = 7;
  localparam int MUL_OP_W = 35;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CNT - 1);

  localparam logic [29:0]      NS_PER_S     = 30'd1000000000;
  localparam logic [CNT_W-1:0] MUL_LIMIT    = 64'd18446744073;
  localparam logic [LVL_W-1:0] CEIL_RESET   = 8'd100;
  localparam int               KIB_SHIFT    = 10;

  typedef struct packed {
    logic [CNT_W-1:0] timestamp_ns;
    logic [CNT_W-1:0] tx_byte_count;
    logic [CNT_W-1:0] rx_byte_count;
    logic [CNT_W-1:0] tx_frame_count;
    logic [CNT_W-1:0] rx_frame_count;
  } ltrm_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]      tx_byte_rate;
    logic [CNT_W-1:0]      rx_byte_rate;
    logic [CNT_W-1:0]      tx_frame_rate;
    logic [CNT_W-1:0]      rx_frame_rate;
    logic [LVL_W-1:0]      tx_level;
    logic [LVL_W-1:0]      rx_level;
    logic [SLOT_OUT_W-1:0] history_slot;
  } ltrm_out_t;

  typedef enum logic [1:0] {
    RATE_QUOT,
    RATE_MUL,
    RATE_SAT
  } ltrm_rate_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DELTA,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_SMALL,
    ST_DIV_LARGE,
    ST_POSTMUL,
    ST_COMMIT,
    ST_FINISH
  } ltrm_state_t;

  typedef struct packed {
    logic             load;
    logic             delta_en;
    logic             mul_en;
    logic             mul_sel_quot;
    logic             div_start;
    logic             div_sel_delta;
    logic             rate_we;
    ltrm_rate_src_t   rate_src;
    logic             commit;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } ltrm_cmd_t;

  typedef struct packed {
    logic upd;
    logic small_delta;
    logic quot_big;
    logic div_done;
    logic out_free;
  } ltrm_status_t;

endpackage

FILE: sv/ltrm_div.sv
// ----------------------------------------------------------------------------
// ltrm_div
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ltrm_div
  import ltrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] num,
  input  logic [CNT_W-1:0] den,
  output logic [CNT_W-1:0] quot,
  output logic             done
);

  localparam int STEP_W = $clog2(CNT_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CNT_W - 1);

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    shifted;

  assign shifted = {rem_r, quo_r[CNT_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[CNT_W]) begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[CNT_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CNT_W-1:0];
        quo_nxt = {quo_r[CNT_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule

FILE: sv/ltrm_dp.sv
// ----------------------------------------------------------------------------
// ltrm_dp
// Datapath: snapshot and previous-counter registers, delta, constant
// multiplier, shared divider, rate registers, output register and slot count.
// ----------------------------------------------------------------------------
module ltrm_dp
  import ltrm_pkg::*;
#(
  parameter int HISTORY_SLOTS = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ltrm_cmd_t        cmd,
  output ltrm_status_t     status,
  input  ltrm_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ltrm_out_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [LVL_W-1:0] cfg_wr_data
);

  localparam int SLOT_W = (HISTORY_SLOTS > 2) ? $clog2(HISTORY_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_SLOTS - 1);

  ltrm_in_t          in_r;
  logic [CNT_W-1:0]  last_time_r;
  logic              have_r;
  logic [CNT_W-1:0]  last_cnt_r [NUM_CNT];
  logic [CNT_W-1:0]  rate_r [NUM_CNT];
  logic [CNT_W-1:0]  delta_r;
  logic [CNT_W-1:0]  mul_r;
  logic [LVL_W-1:0]  ceil_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  ltrm_out_t         out_r;
  logic              out_valid_r;

  logic [CNT_W-1:0]      cnt_in [NUM_CNT];
  logic [CNT_W-1:0]      cur_cnt;
  logic [CNT_W-1:0]      prev_cnt;
  logic                  time_adv;
  logic [MUL_OP_W-1:0]   mul_op;
  logic [CNT_W:0]        mul_full;
  logic [CNT_W-1:0]      div_num;
  logic [CNT_W-1:0]      div_quot;
  logic                  div_done;
  logic [CNT_W-1:0]      rate_wdata;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

  function automatic logic [LVL_W-1:0] clip_level(input logic [CNT_W-1:0] rate,
                                                  input logic [LVL_W-1:0] ceil_kib);
    logic [CNT_W-KIB_SHIFT-1:0] kib;
    kib = rate[CNT_W-1:KIB_SHIFT];
    if (kib > {{(CNT_W-KIB_SHIFT-LVL_W){1'b0}}, ceil_kib}) begin
      return ceil_kib;
    end
    return kib[LVL_W-1:0];
  endfunction

  assign cnt_in[0] = in_r.tx_byte_count;
  assign cnt_in[1] = in_r.rx_byte_count;
  assign cnt_in[2] = in_r.tx_frame_count;
  assign cnt_in[3] = in_r.rx_frame_count;

  assign cur_cnt  = cnt_in[cmd.idx];
  assign prev_cnt = last_cnt_r[cmd.idx];
  assign time_adv = in_r.timestamp_ns > last_time_r;

  assign mul_op   = cmd.mul_sel_quot ? div_quot[MUL_OP_W-1:0] : delta_r[MUL_OP_W-1:0];
  assign mul_full = mul_op * NS_PER_S;
  assign div_num  = cmd.div_sel_delta ? delta_r : mul_r;

  ltrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (in_r.timestamp_ns - last_time_r),
    .quot  (div_quot),
    .done  (div_done)
  );

  always_comb begin
    case (cmd.rate_src)
      RATE_QUOT: rate_wdata = div_quot;
      RATE_MUL:  rate_wdata = mul_r;
      RATE_SAT:  rate_wdata = '1;
      default:   rate_wdata = '1;
    endcase
  end

  assign slot_nxt  = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  assign slot_wide = {{SLOT_OUT_W{1'b0}}, slot_r};

  assign status.upd         = have_r && time_adv;
  assign status.small_delta = delta_r <= MUL_LIMIT;
  assign status.quot_big    = div_quot > MUL_LIMIT;
  assign status.div_done    = div_done;
  assign status.out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      have_r      <= 1'b0;
      ceil_r      <= CEIL_RESET;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        last_cnt_r[i] <= '0;
        rate_r[i]     <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        ceil_r <= cfg_wr_data;
      end
      if (cmd.rate_we) begin
        rate_r[cmd.idx] <= rate_wdata;
      end
      if (cmd.commit) begin
        if (!have_r || time_adv) begin
          last_time_r <= in_r.timestamp_ns;
        end
        have_r <= 1'b1;
        for (int i = 0; i < NUM_CNT; i++) begin
          last_cnt_r[i] <= cnt_in[i];
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        slot_r      <= slot_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.delta_en) begin
      delta_r <= (cur_cnt > prev_cnt) ? cur_cnt - prev_cnt : '0;
    end
    if (cmd.mul_en) begin
      mul_r <= mul_full[CNT_W-1:0];
    end
    if (cmd.out_load) begin
      out_r.tx_byte_rate  <= rate_r[0];
      out_r.rx_byte_rate  <= rate_r[1];
      out_r.tx_frame_rate <= rate_r[2];
      out_r.rx_frame_rate <= rate_r[3];
      out_r.tx_level      <= clip_level(rate_r[0], ceil_r);
      out_r.rx_level      <= clip_level(rate_r[1], ceil_r);
      out_r.history_slot  <= slot_wide[SLOT_OUT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/ltrm_ctrl.sv
// ----------------------------------------------------------------------------
// ltrm_ctrl
// Controller: when time has advanced, walks the four counters through delta, scale and divide steps,
// then commits the snapshot and hands the result to the output register.
// ----------------------------------------------------------------------------
module ltrm_ctrl
  import ltrm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output ltrm_cmd_t    cmd,
  input  ltrm_status_t status
);

  ltrm_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.rate_src = RATE_QUOT;
    cmd.idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        idx_nxt   = '0;
        state_nxt = status.upd ? ST_DELTA : ST_COMMIT;
      end
      ST_DELTA: begin
        cmd.delta_en = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.small_delta) begin
          cmd.mul_en = 1'b1;
          state_nxt  = ST_DIV_START;
        end else begin
          cmd.div_start     = 1'b1;
          cmd.div_sel_delta = 1'b1;
          state_nxt         = ST_DIV_LARGE;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_SMALL;
      end
      ST_DIV_SMALL: begin
        if (status.div_done) begin
          cmd.rate_we  = 1'b1;
          cmd.rate_src = RATE_QUOT;
          idx_nxt      = idx_r + 1'b1;
          state_nxt    = (idx_r == IDX_LAST) ? ST_COMMIT : ST_DELTA;
        end
      end
      ST_DIV_LARGE: begin
        if (status.div_done) begin
          if (status.quot_big) begin
            cmd.rate_we  = 1'b1;
            cmd.rate_src = RATE_SAT;
            idx_nxt      = idx_r + 1'b1;
            state_nxt    = (idx_r == IDX_LAST) ? ST_COMMIT : ST_DELTA;
          end else begin
            cmd.mul_en       = 1'b1;
            cmd.mul_sel_quot = 1'b1;
            state_nxt        = ST_POSTMUL;
          end
        end
      end
      ST_POSTMUL: begin
        cmd.rate_we  = 1'b1;
        cmd.rate_src = RATE_MUL;
        idx_nxt      = idx_r + 1'b1;
        state_nxt    = (idx_r == IDX_LAST) ? ST_COMMIT : ST_DELTA;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/link_throughput_rate_meter.sv
// ----------------------------------------------------------------------------
// link_throughput_rate_meter: per-second link rates from counter snapshots
// If time advanced, each of four rates passes over the 64-step shared divider (a saturated
// rate skips the multiply), else only commits; output may stall; next item taken after output load
// Sync reset clears rates, snapshot state and slot; level ceiling resets to 100.
// ----------------------------------------------------------------------------
module link_throughput_rate_meter
  import ltrm_pkg::*;
#(
  parameter int HISTORY_SLOTS = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ltrm_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ltrm_out_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [LVL_W-1:0] cfg_wr_data
);

  ltrm_cmd_t    cmd;
  ltrm_status_t status;

  ltrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  ltrm_dp #(
    .HISTORY_SLOTS (HISTORY_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule
